### design/ppm_ascii_rgba_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// ppm_ascii_rgba_parser_unit_defines.svh
// Assertion macros shared by the parser checks.
// ----------------------------------------------------------------------------
`ifndef PPM_ASCII_RGBA_PARSER_UNIT_DEFINES_SVH
`define PPM_ASCII_RGBA_PARSER_UNIT_DEFINES_SVH

// property checked outside reset
`define PPM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define PPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Types and constants of the ASCII PPM (P3) to RGBA parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0] VALUE_MAX    = 16'hFFFF;
  localparam logic [2:0]  HEADER_DONE  = 3'd4;
  localparam logic [2:0]  TOK_WIDTH    = 3'd1;
  localparam logic [2:0]  TOK_HEIGHT   = 3'd2;

  localparam logic [1:0] KIND_WIDTH  = 2'd0;
  localparam logic [1:0] KIND_HEIGHT = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;

  localparam logic [1:0] COMP_FIRST  = 2'd0;
  localparam logic [1:0] COMP_SECOND = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] dimension;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
  } out_item_t;

  typedef struct packed {
    logic        in_comment;
    logic        token_active;
    logic [15:0] token_value;
    logic        token_frozen;
    logic [2:0]  token_index;
    logic [1:0]  component_index;
    logic [7:0]  held_first;
    logic [7:0]  held_second;
  } parse_state_t;

  // result of one byte through the step logic
  typedef struct packed {
    logic         emit;
    out_item_t    item;
    parse_state_t state_next;
  } step_result_t;

endpackage

`default_nettype wire

### design/ppm_step.sv
// ----------------------------------------------------------------------------
// ppm_step
// Per-byte parse logic: comment tracking, token accumulation, token close.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_step (
  input  wire ppm_pkg::in_item_t     item,
  input  wire ppm_pkg::parse_state_t state,
  output ppm_pkg::step_result_t      result
);

  ppm_pkg::parse_state_t cur;
  ppm_pkg::parse_state_t nxt;
  ppm_pkg::out_item_t    res;
  logic        emit;
  logic        is_sep;
  logic        is_digit;
  logic [19:0] scaled;
  logic [7:0]  comp;

  always_comb begin
    cur = item.start_of_image ? '0 : state;
    nxt = cur;
    res = '0;
    emit = 1'b0;
    comp = cur.token_value[7:0];
    is_sep = (item.data_byte == ppm_pkg::CH_SPACE) || (item.data_byte == ppm_pkg::CH_TAB) ||
             (item.data_byte == ppm_pkg::CH_CR) || (item.data_byte == ppm_pkg::CH_LF);
    is_digit = (item.data_byte >= ppm_pkg::CH_ZERO) && (item.data_byte <= ppm_pkg::CH_NINE);
    // value * 10 + digit
    scaled = {1'b0, cur.token_value, 3'b000} + {3'b000, cur.token_value, 1'b0}
             + {16'h0000, item.data_byte[3:0]};

    if (item.data_byte == ppm_pkg::CH_HASH) begin
      nxt.in_comment = 1'b1;
    end else if (cur.in_comment) begin
      if (item.data_byte == ppm_pkg::CH_LF) begin
        nxt.in_comment = 1'b0;
      end
    end else if (is_sep) begin
      if (cur.token_active) begin
        nxt.token_active = 1'b0;
        nxt.token_value  = '0;
        nxt.token_frozen = 1'b0;
        if (cur.token_index < ppm_pkg::HEADER_DONE) begin
          nxt.token_index = cur.token_index + 3'd1;
        end
        if (cur.token_index == ppm_pkg::TOK_WIDTH) begin
          emit = 1'b1;
          res.result_kind = ppm_pkg::KIND_WIDTH;
          res.dimension   = cur.token_value;
        end else if (cur.token_index == ppm_pkg::TOK_HEIGHT) begin
          emit = 1'b1;
          res.result_kind = ppm_pkg::KIND_HEIGHT;
          res.dimension   = cur.token_value;
        end else if (cur.token_index >= ppm_pkg::HEADER_DONE) begin
          if (cur.component_index == ppm_pkg::COMP_FIRST) begin
            nxt.held_first      = comp;
            nxt.component_index = ppm_pkg::COMP_SECOND;
          end else if (cur.component_index == ppm_pkg::COMP_SECOND) begin
            nxt.held_second     = comp;
            nxt.component_index = cur.component_index + 2'd1;
          end else begin
            emit = 1'b1;
            res.result_kind = ppm_pkg::KIND_PIXEL;
            res.byte_zero   = cur.held_second;
            res.byte_one    = cur.held_first;
            res.byte_two    = comp;
            res.byte_three  = ppm_pkg::ALPHA_OPAQUE;
            nxt.component_index = ppm_pkg::COMP_FIRST;
          end
        end
      end
    end else begin
      nxt.token_active = 1'b1;
      if (is_digit) begin
        if (!cur.token_frozen) begin
          nxt.token_value = (|scaled[19:16]) ? ppm_pkg::VALUE_MAX : scaled[15:0];
        end
      end else begin
        nxt.token_frozen = 1'b1;
      end
    end
  end

  assign result.emit       = emit;
  assign result.item       = res;
  assign result.state_next = nxt;

endmodule

`default_nettype wire

### design/ppm_ascii_rgba_parser_unit.sv
// ----------------------------------------------------------------------------
// ppm_ascii_rgba_parser_unit
// ASCII PPM (P3) byte stream parser: reports width, height and RGBA pixels.
// ----------------------------------------------------------------------------
//  channel | signals                        | carries
//  --------+--------------------------------+--------------------------------
//  in      | in_valid, in_ready, in_data    | one text byte + start_of_image
//  out     | out_valid, out_ready, out_data | width, height or one pixel word
//
//  One byte per cycle sustained while no output word stalls; a result passes
//  the input register, then the parse logic into the output register.
//  The parse state update is a registered loop around the step logic.
//  rst clears the parse state and both valid flags.
//  A stalled output word holds; the input register still takes a byte as
//  long as it is empty.
`default_nettype none

module ppm_ascii_rgba_parser_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire ppm_pkg::in_item_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ppm_pkg::out_item_t  out_data
);

  ppm_pkg::in_item_t     in_reg;
  logic                  in_reg_valid;
  ppm_pkg::parse_state_t state;
  ppm_pkg::step_result_t step;
  logic                  advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_reg_valid || advance;

  ppm_step u_step (
    .item   (in_reg),
    .state  (state),
    .result (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
      state        <= '0;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_reg_valid && step.emit;
        if (in_reg_valid) begin
          state <= step.state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg <= in_data;
    end
    if (advance && in_reg_valid) begin
      out_data <= step.item;
    end
  end

endmodule

`default_nettype wire

### design/ppm_checker.sv
// ----------------------------------------------------------------------------
// ppm_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ppm_ascii_rgba_parser_unit_defines.svh"

module ppm_checker (
  input wire                     clk,
  input wire                     rst,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire ppm_pkg::out_item_t out_data
);

  `PPM_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "out_valid after reset")

  `PPM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")

  `PPM_ASSERT(a_pixel_form, clk, rst, out_valid && out_data.result_kind == ppm_pkg::KIND_PIXEL |-> out_data.byte_three == ppm_pkg::ALPHA_OPAQUE && out_data.dimension == 16'h0000, "bad pixel word")

  `PPM_ASSERT(a_dim_form, clk, rst, out_valid && out_data.result_kind != ppm_pkg::KIND_PIXEL |-> (out_data.result_kind == ppm_pkg::KIND_WIDTH || out_data.result_kind == ppm_pkg::KIND_HEIGHT) && out_data.byte_zero == 8'h00 && out_data.byte_one == 8'h00 && out_data.byte_two == 8'h00 && out_data.byte_three == 8'h00, "bad dimension word")

endmodule

bind ppm_ascii_rgba_parser_unit ppm_checker u_ppm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
